FILE: rtl/core/minifloat_format_converter_macros.svh
// Assertion macros for the minifloat format converter.
// Each check is sampled on the rising clock edge and is disabled while reset is high.
`ifndef MINIFLOAT_FORMAT_CONVERTER_MACROS_SVH
`define MINIFLOAT_FORMAT_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every sampled edge.
`define MFC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// If the antecedent holds, the consequent must hold in the next cycle.
`define MFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MFC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define MFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/core/mfc_pkg.sv
`timescale 1ns / 1ps

package mfc_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 9;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGN_ENABLE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MANTISSA_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT_OFFSET = 2'd3;

  // Operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Single-precision field layout
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SP_MAN_W   = 23;
  localparam int unsigned SP_EXP_W   = 8;
  localparam logic [SP_EXP_W-1:0] SP_EXP_ALL_ONES = 8'hFF;
  localparam int unsigned SP_BIAS    = 127;

  // Legal width ranges
  localparam logic [3:0] EXP_W_MIN = 4'd1;
  localparam logic [3:0] EXP_W_MAX = 4'd8;
  localparam logic [4:0] MAN_W_MIN = 5'd1;
  localparam logic [4:0] MAN_W_MAX = 5'd23;

  typedef struct packed {
    logic              sign_enable;
    logic [3:0]        exponent_width;
    logic [4:0]        mantissa_width;
    logic signed [8:0] exponent_offset;
  } cfg_t;

  // Reset gives IEEE half precision
  localparam cfg_t CFG_RESET = '{
    sign_enable:     1'b1,
    exponent_width:  4'd5,
    mantissa_width:  5'd10,
    exponent_offset: 9'sd15
  };

endpackage

FILE: rtl/core/mfc_req_if.sv
`timescale 1ns / 1ps

// Input channel: operation and word to convert
interface mfc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] word_in;

  modport source (output valid, output op, output word_in, input ready);
  modport sink   (input valid, input op, input word_in, output ready);
endinterface

FILE: rtl/core/mfc_rsp_if.sv
`timescale 1ns / 1ps

// Output channel: converted word
interface mfc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_out;

  modport source (output valid, output word_out, input ready);
  modport sink   (input valid, input word_out, output ready);
endinterface

FILE: rtl/core/mfc_convert.sv
`timescale 1ns / 1ps

// Single-pass bit-field conversion between float32 and the configured minifloat
module mfc_convert (
  input  mfc_pkg::cfg_t cfg,
  input  logic          op,
  input  logic [31:0]   word_in,
  output logic [31:0]   word_out
);

  logic [3:0]         ew;
  logic [4:0]         mw;
  logic [7:0]         maxe;
  logic [4:0]         man_shift;
  logic [4:0]         sign_pos;

  logic               enc_neg;
  logic               flush;
  logic [7:0]         be;
  logic [22:0]        man;
  logic signed [10:0] e_raw;
  logic               is_normal;
  logic               kill;
  logic [7:0]         nbe;
  logic [22:0]        man_k;
  logic [22:0]        nman;
  logic               enc_sign;
  logic [31:0]        enc_word;

  logic               dec_sgn;
  logic [7:0]         dec_e;
  logic [22:0]        dec_field;
  logic [22:0]        dec_man;
  logic [8:0]         dec_e9;
  logic [31:0]        dec_word;

  // Clamp the format widths to their legal range
  always_comb begin
    if (cfg.exponent_width < mfc_pkg::EXP_W_MIN) begin
      ew = mfc_pkg::EXP_W_MIN;
    end else if (cfg.exponent_width > mfc_pkg::EXP_W_MAX) begin
      ew = mfc_pkg::EXP_W_MAX;
    end else begin
      ew = cfg.exponent_width;
    end
    if (cfg.mantissa_width < mfc_pkg::MAN_W_MIN) begin
      mw = mfc_pkg::MAN_W_MIN;
    end else if (cfg.mantissa_width > mfc_pkg::MAN_W_MAX) begin
      mw = mfc_pkg::MAN_W_MAX;
    end else begin
      mw = cfg.mantissa_width;
    end
  end

  assign maxe      = 8'((9'd1 << ew) - 9'd1);
  assign man_shift = 5'd23 - mw;
  assign sign_pos  = 5'({2'b00, ew} + {1'b0, mw});

  // Encode: rebias, saturate to infinity, flush to zero, truncate mantissa
  always_comb begin
    enc_neg  = word_in[31];
    flush    = !cfg.sign_enable && enc_neg && (word_in[30:23] != '0);
    be       = flush ? '0 : word_in[30:23];
    man      = flush ? '0 : word_in[22:0];
    enc_sign = cfg.sign_enable && enc_neg;

    e_raw = $signed({3'b000, be}) - 11'sd127
            + $signed({{2{cfg.exponent_offset[8]}}, cfg.exponent_offset});
    is_normal = (be != mfc_pkg::SP_EXP_ALL_ONES) && (be != '0);

    kill = 1'b0;
    if (is_normal) begin
      if (e_raw >= $signed({3'b000, maxe})) begin
        nbe  = maxe;
        kill = 1'b1;
      end else if (e_raw <= 11'sd0) begin
        nbe  = '0;
        kill = 1'b1;
      end else begin
        nbe = e_raw[7:0];
      end
    end else if (be == mfc_pkg::SP_EXP_ALL_ONES) begin
      nbe = maxe;
    end else begin
      nbe = '0;
    end

    man_k = kill ? '0 : man;
    nman  = man_k >> man_shift;
    // NaN whose kept payload would vanish keeps a nonzero mantissa
    if ((be == mfc_pkg::SP_EXP_ALL_ONES) && (man_k != '0) && (nman == '0)) begin
      nman = 23'd1;
    end

    enc_word = (32'(enc_sign) << sign_pos) | (32'(nbe) << mw) | 32'(nman);
  end

  // Decode: rebias exponent, left-align mantissa; bit 8 of exponent ORs into sign
  always_comb begin
    dec_sgn   = cfg.sign_enable && word_in[sign_pos];
    dec_e     = 8'(word_in >> mw) & maxe;
    dec_field = 23'(word_in & ((32'd1 << mw) - 32'd1));
    dec_man   = dec_field << man_shift;
    if (dec_e == maxe) begin
      dec_e9 = 9'(mfc_pkg::SP_EXP_ALL_ONES);
    end else if (dec_e != '0) begin
      dec_e9 = {1'b0, dec_e} - cfg.exponent_offset + 9'(mfc_pkg::SP_BIAS);
    end else begin
      dec_e9 = '0;
    end
    dec_word = {dec_e9[8] | dec_sgn, dec_e9[7:0], dec_man};
  end

  assign word_out = (op == mfc_pkg::OP_DECODE) ? dec_word : enc_word;

endmodule

FILE: rtl/core/minifloat_format_converter.sv
`timescale 1ns / 1ps

// Channel  Role    Payload                Handshake
// -------  ------  ---------------------  -----------
// req      sink    op, word_in (32 bits)  valid/ready
// rsp      source  word_out (32 bits)     valid/ready
// cfg      write   cfg_index, cfg_data    cfg_we
//
// One transaction per cycle sustained while rsp is ready; a taken request is
// held in the input register, then in the result register, from which it is
// offered on rsp.
// rst (synchronous) empties both stages and loads half-precision settings.
// A stall on rsp holds the result register; req keeps flowing into the input
// register while it is free or moves on in the same cycle.
`include "minifloat_format_converter_macros.svh"

module minifloat_format_converter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  mfc_req_if.sink                           req,
  mfc_rsp_if.source                         rsp
);

  mfc_pkg::cfg_t cfg;

  logic        s1_v;
  logic        s1_op;
  logic [31:0] s1_word;
  logic        r_v;
  logic [31:0] r_word;
  logic        r_load;
  logic        req_take;
  logic [31:0] conv_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= mfc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mfc_pkg::CFG_SIGN_ENABLE:     cfg.sign_enable     <= cfg_data[0];
        mfc_pkg::CFG_EXPONENT_WIDTH:  cfg.exponent_width  <= cfg_data[3:0];
        mfc_pkg::CFG_MANTISSA_WIDTH:  cfg.mantissa_width  <= cfg_data[4:0];
        mfc_pkg::CFG_EXPONENT_OFFSET: cfg.exponent_offset <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Stage handshakes
  assign r_load    = s1_v && (!r_v || rsp.ready);
  assign req.ready = !s1_v || r_load;
  assign req_take  = req.valid && req.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (req_take) begin
      s1_v <= 1'b1;
    end else if (r_load) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_op   <= req.op;
      s1_word <= req.word_in;
    end
  end

  mfc_convert u_convert (
    .cfg      (cfg),
    .op       (s1_op),
    .word_in  (s1_word),
    .word_out (conv_word)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (r_load) begin
      r_v <= 1'b1;
    end else if (rsp.ready) begin
      r_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_load) begin
      r_word <= conv_word;
    end
  end

  assign rsp.valid    = r_v;
  assign rsp.word_out = r_word;

  // Checks
  `MFC_ASSERT_NEXT(a_stage_moves, clk, rst, s1_v && r_load, r_v, "converted word was lost")
  `MFC_ASSERT_NEXT(a_result_holds, clk, rst, r_v && !rsp.ready,
                   r_v && $stable(r_word), "stalled result changed")
  `MFC_ASSERT_ALWAYS(a_cfg_reset, clk, rst, !$past(rst) || (cfg == mfc_pkg::CFG_RESET),
                     "config not at reset values")

endmodule

FILE: tb/sv/tb_minifloat_format_converter.sv
`timescale 1ns / 1ps

module tb_minifloat_format_converter;
  import mfc_pkg::*;

  localparam int RUN_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mfc_req_if req_ch();
  mfc_rsp_if rsp_ch();

  minifloat_format_converter DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the format registers
  logic fmt_sign = CFG_RESET.sign_enable;
  logic [3:0] fmt_exp_w = CFG_RESET.exponent_width;
  logic [4:0] fmt_man_w = CFG_RESET.mantissa_width;
  logic signed [8:0] fmt_bias = $signed(CFG_RESET.exponent_offset);

  logic [31:0] expected_words[$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 62;
  int hold_left = 0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Effective widths after clamping
  function automatic int unsigned exp_width_used();
    if (fmt_exp_w < EXP_W_MIN) return 32'(EXP_W_MIN);
    if (fmt_exp_w > EXP_W_MAX) return 32'(EXP_W_MAX);
    return 32'(fmt_exp_w);
  endfunction

  function automatic int unsigned man_width_used();
    if (fmt_man_w < MAN_W_MIN) return 32'(MAN_W_MIN);
    if (fmt_man_w > MAN_W_MAX) return 32'(MAN_W_MAX);
    return 32'(fmt_man_w);
  endfunction

  // Single precision to minifloat
  function automatic logic [31:0] minifloat_encode(input logic [31:0] v);
    int unsigned ew, mw;
    logic [7:0] be;
    logic [22:0] man;
    logic neg;
    int maxe, e;
    logic [31:0] res, nbe, nman;
    ew = exp_width_used();
    mw = man_width_used();
    be = v[30:23];
    man = v[22:0];
    neg = v[31];
    maxe = (1 << ew) - 1;
    res = '0;
    // unsigned formats zero out negative normals, infinities and NaNs
    if (fmt_sign && neg) begin
      res[ew + mw] = 1'b1;
    end else if (neg && be != 8'd0) begin
      be = 8'd0;
      man = '0;
    end
    if (be != SP_EXP_ALL_ONES && be != 8'd0) begin
      e = int'(be) - int'(SP_BIAS) + int'(fmt_bias);
      if (e >= maxe) begin
        e = maxe;
        man = '0;
      end
      if (e <= 0) begin
        e = 0;
        man = '0;
      end
      nbe = e;
    end else if (be == SP_EXP_ALL_ONES) begin
      nbe = maxe;
    end else begin
      nbe = '0;
    end
    nman = {9'd0, man} >> (23 - mw);
    // keep a NaN a NaN when its payload is truncated away
    if (be == SP_EXP_ALL_ONES && man != '0 && nman == '0) nman = 32'd1;
    return res | (nbe << mw) | nman;
  endfunction

  // Minifloat to single precision
  function automatic logic [31:0] minifloat_decode(input logic [31:0] w);
    int unsigned ew, mw;
    logic [31:0] maxe, e, man;
    logic sgn;
    ew = exp_width_used();
    mw = man_width_used();
    maxe = (32'd1 << ew) - 32'd1;
    sgn = fmt_sign ? w[ew + mw] : 1'b0;
    e = (w >> mw) & maxe;
    man = (w & ((32'd1 << mw) - 32'd1)) << (23 - mw);
    if (e == maxe) e = 32'd255;
    else if (e != 32'd0) e = e - 32'(fmt_bias) + 32'd127;
    return {sgn, 31'd0} | (e << 23) | man;
  endfunction

  function automatic logic [31:0] predict_word(input logic op, input logic [31:0] w);
    return (op == OP_DECODE) ? minifloat_decode(w) : minifloat_encode(w);
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    logic [31:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("word_out %h arrived with no transaction pending", rsp_ch.word_out);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (rsp_ch.word_out !== want) begin
          $error("word_out mismatch: expected %h, actual %h", want, rsp_ch.word_out);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random back-pressure, or a counted hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One request transaction, with a random gap in front
  task automatic send_word(input logic op, input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.word_in <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_words.push_back(predict_word(op, w));
  endtask

  task automatic wait_results_done();
    req_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_SIGN_ENABLE:     fmt_sign = data[0];
      CFG_EXPONENT_WIDTH:  fmt_exp_w = data[3:0];
      CFG_MANTISSA_WIDTH:  fmt_man_w = data[4:0];
      CFG_EXPONENT_OFFSET: fmt_bias = $signed(data[8:0]);
      default: ;
    endcase
  endtask

  // Only called with the block drained
  task automatic set_format(input logic s, input logic [3:0] ew, input logic [4:0] mw,
                            input logic signed [8:0] bias);
    write_reg(CFG_SIGN_ENABLE, CFG_DATA_W'(s));
    write_reg(CFG_EXPONENT_WIDTH, CFG_DATA_W'(ew));
    write_reg(CFG_MANTISSA_WIDTH, CFG_DATA_W'(mw));
    write_reg(CFG_EXPONENT_OFFSET, bias);
    cfg_we <= 1'b0;
  endtask

  // Encode stimulus biased toward range limits, specials and short payloads
  function automatic logic [31:0] random_encode_word();
    int e;
    logic s;
    logic [7:0] be;
    logic [31:0] w;
    s = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: w = $urandom;
      1: begin
        e = 127 - int'(fmt_bias) - 3
            + int'($urandom_range(0, (1 << exp_width_used()) - 1 + 6));
        if (e < 0) e = 0;
        if (e > 255) e = 255;
        w = {s, 8'(e), 23'($urandom)};
      end
      2: begin
        be = $urandom_range(1) ? SP_EXP_ALL_ONES : 8'd0;
        w = {s, be, 23'($urandom >> $urandom_range(31))};
      end
      default: w = {s, 8'($urandom), 23'($urandom >> $urandom_range(31))};
    endcase
    return w;
  endfunction

  // Decode stimulus: raw words, in-format words, and special exponents
  function automatic logic [31:0] random_decode_word();
    int unsigned ew, mw;
    logic [31:0] maxe, ef, w;
    ew = exp_width_used();
    mw = man_width_used();
    maxe = (32'd1 << ew) - 32'd1;
    case ($urandom_range(2))
      0: w = $urandom;
      1: w = $urandom & 32'((64'd1 << (ew + mw + 1)) - 64'd1);
      default: begin
        case ($urandom_range(2))
          0: ef = 32'd0;
          1: ef = maxe;
          default: ef = $urandom;
        endcase
        w = (32'($urandom_range(1)) << (ew + mw)) | ((ef & maxe) << mw)
            | ($urandom & ((32'd1 << mw) - 32'd1));
      end
    endcase
    return w;
  endfunction

  // Half precision straight out of reset
  task automatic test_reset_format();
    send_word(OP_ENCODE, 32'h3F800000);
    send_word(OP_ENCODE, 32'hC0000000);
    send_word(OP_ENCODE, 32'h7F800000);
    send_word(OP_ENCODE, 32'h7F800001);
    send_word(OP_ENCODE, 32'h7FFFFFFF);
    send_word(OP_ENCODE, 32'h47800000);
    send_word(OP_ENCODE, 32'h33000000);
    send_word(OP_ENCODE, 32'h007FFFFF);
    send_word(OP_ENCODE, 32'h80000000);
    send_word(OP_ENCODE, 32'h00000000);
    send_word(OP_DECODE, 32'h00003C00);
    send_word(OP_DECODE, 32'h0000FC00);
    send_word(OP_DECODE, 32'h00007C01);
    send_word(OP_DECODE, 32'hFFFFFFFF);
    send_word(OP_DECODE, 32'h00000001);
    wait_results_done();
  endtask

  // Unsigned format: negatives collapse, sign position ignored on decode
  task automatic test_unsigned_format();
    set_format(1'b0, 4'd5, 5'd10, 9'sd15);
    send_word(OP_ENCODE, 32'hBF800000);
    send_word(OP_ENCODE, 32'h807FFFFF);
    send_word(OP_ENCODE, 32'hFF800000);
    send_word(OP_DECODE, 32'h0000BC00);
    wait_results_done();
  endtask

  // Widest, narrowest and out-of-range widths, bias wrap into bit 31
  task automatic test_width_extremes();
    set_format(1'b1, 4'd8, 5'd23, 9'sd127);
    send_word(OP_ENCODE, 32'h92345678);
    send_word(OP_DECODE, 32'hFF7FFFFF);
    wait_results_done();
    set_format(1'b0, 4'd1, 5'd1, -9'sd128);
    send_word(OP_ENCODE, 32'h3F800000);
    send_word(OP_DECODE, 32'h00000003);
    wait_results_done();
    set_format(1'b1, 4'd0, 5'd31, 9'sd255);
    send_word(OP_ENCODE, 32'h3F800000);
    send_word(OP_DECODE, 32'h00800000);
    wait_results_done();
    set_format(1'b1, 4'd15, 5'd0, -9'sd128);
    send_word(OP_DECODE, 32'h000001FC);
    send_word(OP_ENCODE, 32'h7F000000);
    wait_results_done();
  endtask

  task automatic apply_random_format(input int kind);
    logic s;
    logic [3:0] ew;
    logic [4:0] mw;
    logic signed [8:0] bias;
    int std_bias;
    s = 1'($urandom_range(1));
    case (kind)
      0: begin
        ew = 4'd8;
        mw = 5'd23;
        bias = 9'sd255;
      end
      1: begin
        ew = 4'd1;
        mw = 5'd1;
        bias = -9'sd128;
      end
      2: begin
        // any value the register fields hold
        ew = 4'($urandom);
        mw = 5'($urandom);
        bias = 9'($urandom);
      end
      default: begin
        ew = 4'($urandom_range(1, 8));
        mw = 5'($urandom_range(1, 23));
        std_bias = (1 << (ew - 1)) - 1;
        case ($urandom_range(2))
          0: bias = 9'(std_bias);
          1: bias = 9'(std_bias + int'($urandom_range(0, 8)) - 4);
          default: bias = 9'($urandom);
        endcase
      end
    endcase
    set_format(s, ew, mw, bias);
  endtask

  task automatic test_random_formats();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 5; k++) begin
        apply_random_format(k);
        for (int n = 0; n < 60; n++) begin
          if ($urandom_range(1)) send_word(OP_DECODE, random_decode_word());
          else send_word(OP_ENCODE, random_encode_word());
        end
        wait_results_done();
      end
    end
  endtask

  // Long receiver hold-off with the sender pushing back to back
  task automatic test_output_stall();
    set_format(1'b1, 4'd5, 5'd10, 9'sd15);
    send_idle_pct = 0;
    recv_idle_pct = 30;
    hold_left = 300;
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(1)) send_word(OP_DECODE, random_decode_word());
      else send_word(OP_ENCODE, random_encode_word());
    end
    wait_results_done();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_ENCODE;
    req_ch.word_in <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_format();
    test_unsigned_format();
    test_width_extremes();
    test_random_formats();
    test_output_stall();

    wait_results_done();
    if (expected_words.size() != 0) begin
      $error("%0d transactions never produced word_out", expected_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mfc_pkg.sv
rtl/core/mfc_req_if.sv
rtl/core/mfc_rsp_if.sv
rtl/core/mfc_convert.sv
rtl/core/minifloat_format_converter.sv
tb/sv/tb_minifloat_format_converter.sv
